/* rtl/bccf_pkg.sv */
// Package for the barrier control client: message constants, phase/error/op codes.
// Used by all modules of the block.
package bccf_pkg;
  localparam int unsigned MSG_WORDS = 16;
  localparam logic [31:0] CTL_HEADER = 32'h4E505543;
  localparam logic [31:0] CTL_API = 32'd1;
  localparam logic [31:0] CTL_KIND_REQUEST = 32'd1;
  localparam logic [31:0] CTL_KIND_REPLY = 32'd2;
  localparam logic [31:0] CTL_VERSION = 32'd1;
  localparam logic [31:0] CTL_CAPS = 32'd7;
  localparam logic [31:0] CTL_BYTES = 32'd64;

  // config register byte addresses
  localparam logic [2:0] CFG_ADDR_NONCE_LOW = 3'd0;
  localparam logic [2:0] CFG_ADDR_NONCE_HIGH = 3'd4;

  localparam logic [1:0] OPC_RESTART = 2'd0;
  localparam logic [1:0] OPC_REQUEST = 2'd1;
  localparam logic [1:0] OPC_ABORT = 2'd2;
  localparam logic [1:0] OPC_REPLY = 2'd3;

  localparam logic [1:0] OP_DISCOVER = 2'd0;
  localparam logic [1:0] OP_BIND = 2'd1;
  localparam logic [1:0] OP_STOP = 2'd2;
  localparam logic [1:0] OP_STATUS = 2'd3;

  localparam logic [2:0] PH_NEW = 3'd0;
  localparam logic [2:0] PH_DISCOVERED = 3'd1;
  localparam logic [2:0] PH_BOUND = 3'd2;
  localparam logic [2:0] PH_STOPPING = 3'd3;
  localparam logic [2:0] PH_PARKED = 3'd4;
  localparam logic [2:0] PH_FAILED = 3'd5;

  localparam logic [3:0] ER_NONE = 4'd0;
  localparam logic [3:0] ER_ARGUMENT = 4'd1;
  localparam logic [3:0] ER_ABORTED = 4'd2;
  localparam logic [3:0] ER_EXHAUSTED = 4'd3;
  localparam logic [3:0] ER_TRANSPORT = 4'd4;
  localparam logic [3:0] ER_ENVELOPE = 4'd5;
  localparam logic [3:0] ER_CAPABILITY = 4'd6;
  localparam logic [3:0] ER_REMOTE = 4'd7;
  localparam logic [3:0] ER_GENERATION = 4'd8;
  localparam logic [3:0] ER_SNAPSHOT = 4'd9;

  localparam logic [1:0] OUT_ACCEPTED = 2'd0;
  localparam logic [1:0] OUT_REJECTED = 2'd1;
  localparam logic [1:0] OUT_IGNORED = 2'd2;
  localparam logic [1:0] OUT_NA = 2'd3;

  // one result word: kind, message word, last, ticket, outcome, phase, error
  typedef struct packed {
    logic [3:0]  error_now;
    logic [2:0]  phase_now;
    logic [1:0]  outcome;
    logic [31:0] issued_ticket;
    logic        last;
    logic [31:0] message_word;
    logic        kind;
  } res_t;

  // request burst description handed from the control core to the emitter
  typedef struct packed {
    logic        start;
    logic [1:0]  op;
    logic [31:0] epoch;
    logic [31:0] ticket;
  } burst_t;

  function automatic logic [31:0] req_word(input logic [3:0] idx, input logic [1:0] op,
                                           input logic [31:0] ep, input logic [31:0] nlo,
                                           input logic [31:0] nhi);
    logic [31:0] w;
    w = '0;
    unique case (idx)
      4'd0: w = CTL_HEADER;
      4'd1: w = CTL_API;
      4'd2: w = CTL_KIND_REQUEST;
      4'd3: w = CTL_VERSION;
      4'd4: w = CTL_BYTES;
      4'd5: w = {30'd0, op};
      4'd6: w = ep;
      4'd7: w = nlo;
      4'd8: w = nhi;
      default: w = '0;
    endcase
    return w;
  endfunction
endpackage

/* rtl/barrier_control_client_fsm.sv */
// Barrier control client: top level, input register, core, emitter and registers.
// Depends on bccf_pkg, bccf_regs, bccf_core, bccf_emit.
//
//  channel | dir | content
//  in_     | in  | tdata: opcode, ticket, link_err, length_ok, reply_word; tlast
//  out_    | out | tdata: message_word, issued_ticket, outcome, phase_now, error_now;
//          |     | tuser: kind; tlast
//  cfg_    | in  | APB, nonce_low at 0x0, nonce_high at 0x4
//
// One word per cycle unless stalled; a request emits 16 words, while in_tready is low.
// Input word is registered, decided combinationally, then held in the output register.
// Reset (sync, active low) leaves the block failed until a restart.
// Output stalls back up through the output register to in_tready.
module barrier_control_client_fsm
  import bccf_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,  // opcode[1:0] ticket[33:2] link_err[34]
                                  // length_ok[35] reply_word[67:36] zero[71:68]
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [79:0]  out_tdata, // message_word[31:0] issued_ticket[63:32]
                                  // outcome[65:64] phase_now[68:66] error_now[72:69]
  output logic         out_tuser, // kind
  output logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  logic        iv_r;
  logic [67:0] id_r;
  logic        il_r;
  logic        st_valid, busy, stall;
  res_t        st_res, out_res;
  burst_t      burst;
  logic [2:0]  ph_now;
  logic [3:0]  er_now;
  logic [31:0] nlo, nhi;
  logic        emit_ready;

  // registered word proceeds when emitter can take a status and no burst runs
  assign stall = iv_r && (busy || (out_tvalid && !out_tready));
  assign in_tready = !stall && !busy;
  assign emit_ready = !stall;

  always_ff @(posedge clk) begin
    if (!rst_n) iv_r <= 1'b0;
    else if (!stall && !busy) iv_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      id_r <= in_tdata[67:0];
      il_r <= in_tlast;
    end
  end

  bccf_regs u_regs (
    .clk(clk), .rst_n(rst_n), .psel(cfg_psel), .penable(cfg_penable),
    .pwrite(cfg_pwrite), .paddr(cfg_paddr), .pwdata(cfg_pwdata),
    .prdata(cfg_prdata), .pready(cfg_pready), .nonce_low(nlo), .nonce_high(nhi)
  );

  bccf_core u_core (
    .clk(clk), .rst_n(rst_n), .iv(iv_r && emit_ready && !busy),
    .opcode(id_r[1:0]), .ticket(id_r[33:2]), .link_err(id_r[34]),
    .length_ok(id_r[35]), .reply_word(id_r[67:36]), .last_word(il_r),
    .nonce_low(nlo), .nonce_high(nhi), .st_valid(st_valid), .st_res(st_res),
    .burst(burst), .ph_now(ph_now), .er_now(er_now)
  );

  bccf_emit u_emit (
    .clk(clk), .rst_n(rst_n), .st_valid(st_valid), .st_res(st_res), .burst(burst),
    .ph_now(ph_now), .er_now(er_now), .nonce_low(nlo), .nonce_high(nhi),
    .busy(busy), .out_valid(out_tvalid), .out_ready(out_tready), .out_res(out_res)
  );

  assign out_tdata = {7'd0, out_res.error_now, out_res.phase_now, out_res.outcome,
                      out_res.issued_ticket, out_res.message_word};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;
endmodule

/* rtl/bccf_regs.sv */
// Configuration registers (session nonce halves) behind an APB-style port.
// Depends on bccf_pkg for the register addresses.
module bccf_regs
  import bccf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [31:0] nonce_low,
  output logic [31:0] nonce_high
);
  logic [31:0] nlo_r, nhi_r;
  logic        wr;

  assign pready = 1'b1;
  assign wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nlo_r <= '0;
      nhi_r <= '0;
    end else if (wr) begin
      if (paddr == CFG_ADDR_NONCE_LOW) nlo_r <= pwdata;
      if (paddr == CFG_ADDR_NONCE_HIGH) nhi_r <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == CFG_ADDR_NONCE_LOW) prdata = nlo_r;
    else if (paddr == CFG_ADDR_NONCE_HIGH) prdata = nhi_r;
  end

  assign nonce_low = nlo_r;
  assign nonce_high = nhi_r;
endmodule

/* rtl/bccf_emit.sv */
// Output stage: status results and 16-word request bursts, with an output register.
// Depends on bccf_pkg.
module bccf_emit
  import bccf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        st_valid,
  input  res_t        st_res,
  input  burst_t      burst,
  input  logic [2:0]  ph_now,
  input  logic [3:0]  er_now,
  input  logic [31:0] nonce_low,
  input  logic [31:0] nonce_high,
  output logic        busy,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        out_res
);
  logic        bact_r, bact_nxt;
  logic [3:0]  bidx_r, bidx_nxt;
  logic [1:0]  bop_r;
  logic [31:0] bep_r, btk_r, bnlo_r, bnhi_r;
  logic [2:0]  bph_r;
  logic [3:0]  ber_r;
  logic        ov_r, ov_nxt;
  res_t        ob_r, ob_nxt;
  logic        take;
  res_t        bw;

  // output register can load when empty or being drained
  assign take = !ov_r || out_ready;
  // input must hold while a burst is still being sent
  assign busy = bact_r;

  always_comb begin
    bw.kind = 1'b0;
    bw.message_word = req_word(bidx_r, bop_r, bep_r, bnlo_r, bnhi_r);
    bw.last = (bidx_r == 4'(MSG_WORDS - 1));
    bw.issued_ticket = btk_r;
    bw.outcome = OUT_ACCEPTED;
    bw.phase_now = bph_r;
    bw.error_now = ber_r;
  end

  always_comb begin
    bact_nxt = bact_r;
    bidx_nxt = bidx_r;
    ov_nxt = ov_r && !out_ready;
    ob_nxt = ob_r;
    if (take) begin
      if (bact_r) begin
        ov_nxt = 1'b1;
        ob_nxt = bw;
        bidx_nxt = bidx_r + 4'd1;
        if (bw.last) bact_nxt = 1'b0;
      end else if (st_valid) begin
        ov_nxt = 1'b1;
        ob_nxt = st_res;
      end
    end
    if (burst.start) begin
      bact_nxt = 1'b1;
      bidx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bact_r <= 1'b0;
      ov_r <= 1'b0;
      bidx_r <= '0;
    end else begin
      bact_r <= bact_nxt;
      ov_r <= ov_nxt;
      bidx_r <= bidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ob_r <= ob_nxt;
    if (burst.start) begin
      bop_r <= burst.op;
      bep_r <= burst.epoch;
      btk_r <= burst.ticket;
      bnlo_r <= nonce_low;
      bnhi_r <= nonce_high;
      bph_r <= ph_now;
      ber_r <= er_now;
    end
  end

  assign out_valid = ov_r;
  assign out_res = ob_r;
endmodule

/* rtl/bccf_core.sv */
// Session state, reply buffer and completion check for one registered input word.
// Depends on bccf_pkg.
module bccf_core
  import bccf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        iv,
  input  logic [1:0]  opcode,
  input  logic [31:0] ticket,
  input  logic        link_err,
  input  logic        length_ok,
  input  logic [31:0] reply_word,
  input  logic        last_word,
  input  logic [31:0] nonce_low,
  input  logic [31:0] nonce_high,
  output logic        st_valid,
  output res_t        st_res,
  output burst_t      burst,
  output logic [2:0]  ph_now,
  output logic [3:0]  er_now
);
  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  err_r, err_nxt;
  logic [31:0] serial_r, serial_nxt, pend_r, pend_nxt;
  logic [1:0]  cop_r, cop_nxt;
  logic [31:0] ep_r, ep_nxt, rel_r, rel_nxt, arm_r, arm_nxt;
  logic [7:0]  prk_r, prk_nxt, rdy_r, rdy_nxt;
  logic [4:0]  drn_r, drn_nxt;
  logic [2:0]  cap_r, cap_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] store [MSG_WORDS];
  logic [31:0] r [MSG_WORDS];
  logic [1:0]  oc;
  logic [1:0]  op;
  logic [31:0] expct;
  logic [31:0] ep, rel, arm, prk32, rdy32, drn32;
  logic        fail;
  logic [3:0]  ferr;

  always_ff @(posedge clk) begin
    if (iv && opcode == OPC_REPLY && cnt_r < 5'(MSG_WORDS))
      store[cnt_r[3:0]] <= reply_word;
  end

  // current word is seen on the last write, so overlay it onto the store view
  always_comb begin
    for (int i = 0; i < MSG_WORDS; i++) begin
      r[i] = store[i];
      if (cnt_r == 5'(i)) r[i] = reply_word;
    end
  end

  always_comb begin
    ep = r[6]; rel = r[14]; arm = r[15];
    prk32 = r[11]; rdy32 = r[12]; drn32 = r[13];
    expct = ep_r;
    if (cop_r == OP_STOP && rel_r == ep_r) expct = ep_r + 32'd1;
    fail = 1'b1;
    if (link_err) ferr = ER_TRANSPORT;
    else if (!length_ok || cnt_r != 5'(MSG_WORDS - 1)) ferr = ER_ARGUMENT;
    else if (r[0] != CTL_HEADER || r[1] != CTL_API || r[2] != CTL_KIND_REPLY ||
             r[3] != CTL_VERSION || r[4] != CTL_BYTES || r[5] != {30'd0, cop_r} ||
             r[7] != nonce_low || r[8] != nonce_high) ferr = ER_ENVELOPE;
    else if (r[10] != CTL_CAPS) ferr = ER_CAPABILITY;
    else if (r[9] != 32'd0) ferr = ER_REMOTE;
    else if (ep == 32'd0 || (cop_r != OP_DISCOVER && ep != expct)) ferr = ER_GENERATION;
    else if (prk32[31:8] != 0 || rdy32[31:8] != 0 || drn32[31:5] != 0 ||
             rel > ep || arm > rel || (rdy32 != 0 && rel != ep) ||
             (drn32 != 0 && prk32 != 32'hFF) || (arm == ep && rdy32 != 32'hFF))
      ferr = ER_SNAPSHOT;
    else if ((cop_r == OP_STOP || cop_r == OP_STATUS) &&
             (rel == ep || rdy32 != 0 || arm == ep)) ferr = ER_SNAPSHOT;
    else if (cop_r == OP_STATUS &&
             (rel != rel_r || arm != arm_r || (prk32[7:0] & prk_r) != prk_r ||
              (drn32[4:0] & drn_r) != drn_r)) ferr = ER_SNAPSHOT;
    else begin
      ferr = ER_NONE;
      fail = 1'b0;
    end
  end

  always_comb begin
    phase_nxt = phase_r; err_nxt = err_r; serial_nxt = serial_r; pend_nxt = pend_r;
    cop_nxt = cop_r; ep_nxt = ep_r; rel_nxt = rel_r; arm_nxt = arm_r;
    prk_nxt = prk_r; rdy_nxt = rdy_r; drn_nxt = drn_r; cap_nxt = cap_r; cnt_nxt = cnt_r;
    st_valid = 1'b0;
    oc = OUT_NA;
    op = OP_DISCOVER;
    burst = '0;
    if (iv) begin
      unique case (opcode)
        OPC_RESTART: begin
          st_valid = 1'b1;
          phase_nxt = PH_NEW; err_nxt = ER_NONE; serial_nxt = '0; pend_nxt = '0;
          cop_nxt = '0; ep_nxt = '0; rel_nxt = '0; arm_nxt = '0;
          prk_nxt = '0; rdy_nxt = '0; drn_nxt = '0; cap_nxt = '0; cnt_nxt = '0;
          if (nonce_low == 0 && nonce_high == 0) begin
            phase_nxt = PH_FAILED; err_nxt = ER_ARGUMENT;
          end
        end
        OPC_ABORT: begin
          st_valid = 1'b1;
          if (phase_r != PH_FAILED) begin
            phase_nxt = PH_FAILED; err_nxt = ER_ABORTED; pend_nxt = '0;
          end
          cnt_nxt = '0;
        end
        OPC_REPLY: begin
          if (cnt_r < 5'd31) cnt_nxt = cnt_r + 5'd1;
          if (last_word) begin
            st_valid = 1'b1;
            cnt_nxt = '0;
            if (ticket == 0 || pend_r == 0 || ticket != pend_r || phase_r == PH_FAILED)
              oc = OUT_IGNORED;
            else if (fail) begin
              oc = OUT_REJECTED;
              phase_nxt = PH_FAILED; err_nxt = ferr; pend_nxt = '0;
            end else begin
              oc = OUT_ACCEPTED;
              if (cop_r == OP_STOP || cop_r == OP_STATUS)
                phase_nxt = (prk32[7:0] == 8'hFF) ? PH_PARKED : PH_STOPPING;
              else
                phase_nxt = (cop_r == OP_DISCOVER) ? PH_DISCOVERED : PH_BOUND;
              ep_nxt = ep; rel_nxt = rel; arm_nxt = arm;
              prk_nxt = prk32[7:0]; rdy_nxt = rdy32[7:0]; drn_nxt = drn32[4:0];
              cap_nxt = r[10][2:0]; pend_nxt = '0;
            end
          end
        end
        default: begin
          if (phase_r == PH_FAILED || pend_r != 0) begin
            st_valid = 1'b1; oc = OUT_IGNORED;
          end else begin
            unique case (phase_r)
              PH_NEW: op = OP_DISCOVER;
              PH_DISCOVERED: op = OP_BIND;
              PH_BOUND: op = OP_STOP;
              default: op = OP_STATUS;
            endcase
            if (phase_r > PH_PARKED || serial_r == 32'hFFFFFFFF ||
                (op == OP_STOP && ep_r == 32'hFFFFFFFF && rel_r == ep_r)) begin
              st_valid = 1'b1; oc = OUT_REJECTED;
              phase_nxt = PH_FAILED;
              err_nxt = (phase_r > PH_PARKED) ? ER_ARGUMENT : ER_EXHAUSTED;
              pend_nxt = '0;
            end else begin
              cop_nxt = op;
              serial_nxt = serial_r + 32'd1;
              pend_nxt = serial_r + 32'd1;
              cnt_nxt = '0;
              burst.start = 1'b1;
              burst.op = op;
              burst.epoch = ep_r;
              burst.ticket = serial_r + 32'd1;
            end
          end
        end
      endcase
    end
    st_res.kind = 1'b1;
    st_res.message_word = '0;
    st_res.last = 1'b1;
    st_res.issued_ticket = '0;
    st_res.outcome = oc;
    st_res.phase_now = phase_nxt;
    st_res.error_now = err_nxt;
    ph_now = phase_nxt;
    er_now = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FAILED; err_r <= ER_NONE; serial_r <= '0; pend_r <= '0;
      cop_r <= '0; ep_r <= '0; rel_r <= '0; arm_r <= '0;
      prk_r <= '0; rdy_r <= '0; drn_r <= '0; cap_r <= '0; cnt_r <= '0;
    end else begin
      phase_r <= phase_nxt; err_r <= err_nxt; serial_r <= serial_nxt; pend_r <= pend_nxt;
      cop_r <= cop_nxt; ep_r <= ep_nxt; rel_r <= rel_nxt; arm_r <= arm_nxt;
      prk_r <= prk_nxt; rdy_r <= rdy_nxt; drn_r <= drn_nxt; cap_r <= cap_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule
